[rtl/core/mrs_pkg.sv]
// Shared command codes, queue sizing and fixed field widths for the range-sum block.
package mrs_pkg;

    // Width of one index field of a request.
    localparam int IDX_W = 6;
    // Width of the value field of a request.
    localparam int VALUE_W = 16;
    // Width of the rectangle sum result.
    localparam int SUM_W = 28;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // Command classes decided by the front.
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_NOP   = 2'd0;  // write outside the matrix
    localparam cmd_t CMD_BAD   = 2'd1;  // query with corners out of order
    localparam cmd_t CMD_WRITE = 2'd2;
    localparam cmd_t CMD_QUERY = 2'd3;

    // Request opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

[rtl/core/mrs_front.sv]
// Front end: takes requests, clamps indices, classifies them and computes base addresses.
module mrs_front
    import mrs_pkg::*;
#(
    parameter int ROWS       = 64,
    parameter int COLS       = 64,
    parameter int DATA_WIDTH = 16,
    localparam int EW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W,
    localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int CB    = (COLS > 1) ? $clog2(COLS) : 1,
    localparam int DEPTH = ROWS * COLS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int EWIDTH = 2 + RB + 2 * CB + 1 + 2 * AW + EW
)
(
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      opcode,
    input  logic [IDX_W-1:0]          row_first,
    input  logic [IDX_W-1:0]          col_first,
    input  logic [IDX_W-1:0]          row_last,
    input  logic [IDX_W-1:0]          col_last,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      q_full,
    input  logic                      clearing,
    output logic                      q_push,
    output logic [EWIDTH-1:0]         q_data
);

    typedef struct packed {
        cmd_t                 cmd;
        logic [RB-1:0]        row;
        logic [CB-1:0]        col;
        logic [CB-1:0]        col_last;
        logic                 has_above;
        logic [AW-1:0]        addr_a;
        logic [AW-1:0]        addr_b;
        logic signed [EW-1:0] value;
    } entry_t;

    localparam logic [AW-1:0] COLS_A = AW'(COLS);

    logic [RB-1:0] r1_sat;
    logic [RB-1:0] r2_sat;
    logic [CB-1:0] c1_sat;
    logic [CB-1:0] c2_sat;
    logic [RB-1:0] row_a;
    logic [RB-1:0] row_b;
    logic          write_ok;
    logic          corners_bad;
    entry_t        entry;

    // Handshake: take a request when the queue has room and memories are cleared.
    assign in_ready = !q_full && !clearing;
    assign q_push   = in_valid && in_ready;

    // Clamp each coordinate to the last row or column of the matrix.
    always_comb
    begin
        r1_sat = (32'(row_first) >= ROWS) ? RB'(ROWS - 1) : RB'(row_first);
        r2_sat = (32'(row_last) >= ROWS) ? RB'(ROWS - 1) : RB'(row_last);
        c1_sat = (32'(col_first) >= COLS) ? CB'(COLS - 1) : CB'(col_first);
        c2_sat = (32'(col_last) >= COLS) ? CB'(COLS - 1) : CB'(col_last);
    end

    assign write_ok    = (32'(row_first) < ROWS) && (32'(col_first) < COLS);
    assign corners_bad = (r1_sat > r2_sat) || (c1_sat > c2_sat);

    // A write and a query bottom read share the first address; the second
    // address is the row just above the query rectangle.
    assign row_a = (opcode == OP_QUERY) ? r2_sat : r1_sat;
    assign row_b = (r1_sat == '0) ? '0 : (r1_sat - RB'(1));

    // Build the queue entry.
    always_comb
    begin
        entry.row       = r1_sat;
        entry.col       = c1_sat;
        entry.col_last  = c2_sat;
        entry.has_above = (r1_sat != '0);
        entry.addr_a    = AW'(AW'(row_a) * COLS_A + AW'(c1_sat));
        entry.addr_b    = AW'(AW'(row_b) * COLS_A + AW'(c1_sat));
        entry.value     = value[EW-1:0];
        unique case (opcode)
            OP_WRITE: entry.cmd = write_ok ? CMD_WRITE : CMD_NOP;
            OP_QUERY: entry.cmd = corners_bad ? CMD_BAD : CMD_QUERY;
            default:  entry.cmd = CMD_NOP;
        endcase
    end

    assign q_data = entry;

endmodule

[rtl/core/mrs_queue.sv]
// Short first-in first-out queue between the front and the back.
module mrs_queue
    import mrs_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_pop;

    assign full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_pop    = pop && pop_valid;
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/mrs_back.sv]
// Back end: element and column-sum memories, the update and query sequencer, result register.
module mrs_back
    import mrs_pkg::*;
#(
    parameter int ROWS       = 64,
    parameter int COLS       = 64,
    parameter int DATA_WIDTH = 16,
    localparam int EW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W,
    localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int CB    = (COLS > 1) ? $clog2(COLS) : 1,
    localparam int DEPTH = ROWS * COLS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = EW + $clog2(ROWS) + 1,
    localparam int EWIDTH = 2 + RB + 2 * CB + 1 + 2 * AW + EW
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    output logic                    q_pop,
    input  logic [EWIDTH-1:0]       q_data,
    output logic                    clearing,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] region_sum,
    output logic                    status
);

    typedef struct packed {
        cmd_t                 cmd;
        logic [RB-1:0]        row;
        logic [CB-1:0]        col;
        logic [CB-1:0]        col_last;
        logic                 has_above;
        logic [AW-1:0]        addr_a;
        logic [AW-1:0]        addr_b;
        logic signed [EW-1:0] value;
    } entry_t;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WOLD  = 3'd2;
    localparam logic [2:0] S_WWALK = 3'd3;
    localparam logic [2:0] S_QRUN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [AW-1:0] COLS_A = AW'(COLS);

    // Memories.
    logic signed [EW-1:0] elem_mem [DEPTH];
    logic signed [CW-1:0] csum_mem [DEPTH];

    entry_t entry;

    // Control state.
    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    // Working registers of the current request.
    logic [RB-1:0]          row_reg;
    logic [RB-1:0]          row_next;
    logic [CB-1:0]          col_reg;
    logic [CB-1:0]          col_next;
    logic [CB-1:0]          col_last_reg;
    logic [CB-1:0]          col_last_next;
    logic                   has_above_reg;
    logic                   has_above_next;
    logic [AW-1:0]          addr_a_reg;
    logic [AW-1:0]          addr_a_next;
    logic [AW-1:0]          addr_b_reg;
    logic [AW-1:0]          addr_b_next;
    logic signed [EW-1:0]   value_reg;
    logic signed [EW-1:0]   value_next;
    logic signed [EW:0]     delta_reg;
    logic signed [EW:0]     delta_next;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;
    logic                   status_reg;
    logic                   status_next;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic signed [SUM_W-1:0] out_sum_next;
    logic                   out_status_reg;
    logic                   out_status_next;

    // Memory ports.
    logic                 elem_we;
    logic [AW-1:0]        elem_waddr;
    logic signed [EW-1:0] elem_wdata;
    logic [AW-1:0]        elem_raddr;
    logic signed [EW-1:0] elem_rd_reg;
    logic                 csum_we;
    logic [AW-1:0]        csum_waddr;
    logic signed [CW-1:0] csum_wdata;
    logic [AW-1:0]        csum_raddr_a;
    logic [AW-1:0]        csum_raddr_b;
    logic signed [CW-1:0] csum_a_reg;
    logic signed [CW-1:0] csum_b_reg;

    logic signed [SUM_W-1:0] above_term;
    logic                    out_free;

    assign entry      = q_data;
    assign clearing   = (state_reg == S_CLEAR);
    assign out_free   = !out_valid_reg || out_ready;
    assign above_term = has_above_reg ? SUM_W'(csum_b_reg) : '0;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        col_last_next   = col_last_reg;
        has_above_next  = has_above_reg;
        addr_a_next     = addr_a_reg;
        addr_b_next     = addr_b_reg;
        value_next      = value_reg;
        delta_next      = delta_reg;
        acc_next        = acc_reg;
        status_next     = status_reg;
        out_sum_next    = out_sum_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        elem_we         = 1'b0;
        elem_waddr      = addr_a_reg;
        elem_wdata      = value_reg;
        elem_raddr      = addr_a_reg;
        csum_we         = 1'b0;
        csum_waddr      = addr_a_reg;
        csum_wdata      = csum_a_reg + CW'(delta_reg);
        csum_raddr_a    = addr_a_reg;
        csum_raddr_b    = addr_b_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Zero one entry of both memories per cycle.
                elem_we    = 1'b1;
                elem_waddr = clr_reg;
                elem_wdata = '0;
                csum_we    = 1'b1;
                csum_waddr = clr_reg;
                csum_wdata = '0;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // Take the next request and start its first reads.
                elem_raddr   = entry.addr_a;
                csum_raddr_a = entry.addr_a;
                csum_raddr_b = entry.addr_b;
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    row_next       = entry.row;
                    col_next       = entry.col;
                    col_last_next  = entry.col_last;
                    has_above_next = entry.has_above;
                    addr_a_next    = entry.addr_a;
                    addr_b_next    = entry.addr_b;
                    value_next     = entry.value;
                    acc_next       = '0;
                    status_next    = 1'b0;
                    unique case (entry.cmd)
                        CMD_WRITE: state_next = S_WOLD;
                        CMD_QUERY: state_next = S_QRUN;
                        CMD_BAD:
                        begin
                            status_next = 1'b1;
                            state_next  = S_DONE;
                        end
                        CMD_NOP:   state_next = S_DONE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_WOLD:
            begin
                // Old element is here: form the change and store the new value.
                delta_next = (EW + 1)'(value_reg) - (EW + 1)'(elem_rd_reg);
                elem_we    = 1'b1;
                state_next = S_WWALK;
            end
            S_WWALK:
            begin
                // Write back one column-sum entry while reading the one below.
                csum_we      = 1'b1;
                csum_raddr_a = addr_a_reg + COLS_A;
                if (row_reg == RB'(ROWS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    row_next    = row_reg + RB'(1);
                    addr_a_next = addr_a_reg + COLS_A;
                end
            end
            S_QRUN:
            begin
                // Add one column's contribution while reading the next column.
                acc_next     = acc_reg + SUM_W'(csum_a_reg) - above_term;
                csum_raddr_a = addr_a_reg + AW'(1);
                csum_raddr_b = addr_b_reg + AW'(1);
                if (col_reg == col_last_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    col_next    = col_reg + CB'(1);
                    addr_a_next = addr_a_reg + AW'(1);
                    addr_b_next = addr_b_reg + AW'(1);
                end
            end
            S_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sum_next    = acc_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        col_last_reg   <= col_last_next;
        has_above_reg  <= has_above_next;
        addr_a_reg     <= addr_a_next;
        addr_b_reg     <= addr_b_next;
        value_reg      <= value_next;
        delta_reg      <= delta_next;
        acc_reg        <= acc_next;
        status_reg     <= status_next;
        out_sum_reg    <= out_sum_next;
        out_status_reg <= out_status_next;
    end

    // Element memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        elem_rd_reg <= elem_mem[elem_raddr];
    end

    // Column-sum memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (csum_we)
        begin
            csum_mem[csum_waddr] <= csum_wdata;
        end
        csum_a_reg <= csum_mem[csum_raddr_a];
        csum_b_reg <= csum_mem[csum_raddr_b];
    end

    assign out_valid  = out_valid_reg;
    assign region_sum = out_sum_reg;
    assign status     = out_status_reg;

endmodule

[rtl/core/mutable_2d_range_sum.sv]
// Top level of the mutable two-dimensional range-sum block.
//
//  Channel  Handshake             Payload
//  -------  --------------------  ---------------------------------------------
//  in       in_valid / in_ready   opcode, row_first, col_first, row_last,
//                                 col_last, value
//  out      out_valid / out_ready region_sum, status
//
// After reset both memories are cleared one entry per cycle, during which in_ready
// stays low. The back end then takes one request at a time: a write updates one
// column-sum entry per cycle on the memory write port, from row_first down to the
// last row, a query adds one column per cycle on the two read ports, from col_first
// to col_last, and an ignored write or a bad query passes straight to the result.
// Up to two requests wait in the queue while the back end works, and a finished
// result waits in the output register while the next request proceeds; only when
// a second result is ready does the back end stall.
module mutable_2d_range_sum
    import mrs_pkg::*;
#(
    parameter int ROWS       = 64,
    parameter int COLS       = 64,
    parameter int DATA_WIDTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      opcode,
    input  logic [IDX_W-1:0]          row_first,
    input  logic [IDX_W-1:0]          col_first,
    input  logic [IDX_W-1:0]          row_last,
    input  logic [IDX_W-1:0]          col_last,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SUM_W-1:0]   region_sum,
    output logic                      status
);

    localparam int EW     = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int RB     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CB     = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DEPTH  = ROWS * COLS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EWIDTH = 2 + RB + 2 * CB + 1 + 2 * AW + EW;

    logic              q_push;
    logic [EWIDTH-1:0] q_in;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic [EWIDTH-1:0] q_out;
    logic              clearing;

    // Front end: request intake and classification.
    mrs_front #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .row_first (row_first),
        .col_first (col_first),
        .row_last  (row_last),
        .col_last  (col_last),
        .value     (value),
        .q_full    (q_full),
        .clearing  (clearing),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // Decoupling queue.
    mrs_queue #(
        .WIDTH (EWIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    // Back end: memories and sequencer.
    mrs_back #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_out),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .region_sum (region_sum),
        .status     (status)
    );

endmodule

[tb/mutable_2d_range_sum_tb.sv]
// Self-checking testbench for the mutable 2D range-sum block: directed, random and stall tests.
`timescale 1ns / 1ps

module mutable_2d_range_sum_tb;
    import mrs_pkg::*;

    localparam int ROWS       = 64;
    localparam int COLS       = 64;
    localparam int DATA_WIDTH = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 100;
    localparam int HOLD_LEN   = 300;

    // One request as the sender presents it.
    typedef struct packed {
        logic                      opcode;
        logic [IDX_W-1:0]          row_first;
        logic [IDX_W-1:0]          col_first;
        logic [IDX_W-1:0]          row_last;
        logic [IDX_W-1:0]          col_last;
        logic signed [VALUE_W-1:0] value;
    } range_req_t;

    // One result as the block returns it.
    typedef struct packed {
        logic signed [SUM_W-1:0] region_sum;
        logic                    status;
    } range_rsp_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      opcode = OP_WRITE;
    logic [IDX_W-1:0]          row_first = '0;
    logic [IDX_W-1:0]          col_first = '0;
    logic [IDX_W-1:0]          row_last = '0;
    logic [IDX_W-1:0]          col_last = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [SUM_W-1:0]   region_sum;
    logic                      status;

    // Shadow copy of the matrix and of its running column sums.
    logic signed [VALUE_W-1:0] matrix_elem [ROWS][COLS];
    int                        col_running [ROWS][COLS];

    range_rsp_t expected_sums[$];

    int  error_count     = 0;
    int  writes_sent     = 0;
    int  queries_sent    = 0;
    int  bad_queries     = 0;
    int  results_checked = 0;
    int  idle_cycles     = 0;
    int  hold_cycles     = 0;
    int  sink_stall_left = 0;
    bit  sender_gaps     = 1'b1;
    bit  sink_stalls     = 1'b1;

    mutable_2d_range_sum #(
        .ROWS       (ROWS),
        .COLS       (COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .row_first  (row_first),
        .col_first  (col_first),
        .row_last   (row_last),
        .col_last   (col_last),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .region_sum (region_sum),
        .status     (status)
    );

    always #4 clk = ~clk;

    // Idle gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic range_req_t make_write(int r, int c, logic signed [VALUE_W-1:0] v);
        range_req_t req;
        req = '0;
        req.opcode    = OP_WRITE;
        req.row_first = IDX_W'(r);
        req.col_first = IDX_W'(c);
        req.value     = v;
        return req;
    endfunction

    function automatic range_req_t make_query(int r1, int c1, int r2, int c2);
        range_req_t req;
        req = '0;
        req.opcode    = OP_QUERY;
        req.row_first = IDX_W'(r1);
        req.col_first = IDX_W'(c1);
        req.row_last  = IDX_W'(r2);
        req.col_last  = IDX_W'(c2);
        return req;
    endfunction

    function automatic int clamp_index(int v, int limit);
        return (v >= limit) ? limit - 1 : v;
    endfunction

    // Update the shadow matrix for one accepted request and queue the result it must give.
    task automatic predict_range_sum(input range_req_t req);
        range_rsp_t want;
        int         r1;
        int         c1;
        int         r2;
        int         c2;
        int         delta;
        int         acc;
        int         above;
        want = '0;
        r1 = int'(req.row_first);
        c1 = int'(req.col_first);
        r2 = int'(req.row_last);
        c2 = int'(req.col_last);
        if (req.opcode == OP_WRITE)
        begin
            writes_sent++;
            // A write outside the matrix changes nothing.
            if (r1 < ROWS && c1 < COLS)
            begin
                delta = int'(req.value) - int'(matrix_elem[r1][c1]);
                for (int i = r1; i < ROWS; i++)
                begin
                    col_running[i][c1] += delta;
                end
                matrix_elem[r1][c1] = req.value;
            end
        end
        else
        begin
            queries_sent++;
            r1 = clamp_index(r1, ROWS);
            r2 = clamp_index(r2, ROWS);
            c1 = clamp_index(c1, COLS);
            c2 = clamp_index(c2, COLS);
            if (r1 > r2 || c1 > c2)
            begin
                bad_queries++;
                want.status = 1'b1;
            end
            else
            begin
                acc = 0;
                for (int j = c1; j <= c2; j++)
                begin
                    above = (r1 > 0) ? col_running[r1 - 1][j] : 0;
                    acc += col_running[r2][j] - above;
                end
                want.region_sum = acc[SUM_W-1:0];
            end
        end
        expected_sums.push_back(want);
    endtask

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input range_req_t req);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= req.opcode;
        row_first <= req.row_first;
        col_first <= req.col_first;
        row_last  <= req.row_last;
        col_last  <= req.col_last;
        value     <= req.value;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_range_sum(req);
    endtask

    // Drop valid right after an accepted request and wait for every outstanding result.
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (expected_sums.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            return 16'sh8000;
        end
        else if (roll == 1)
        begin
            return 16'sh7fff;
        end
        return VALUE_W'($urandom);
    endfunction

    // Random request: writes with random content, ordered queries, some out-of-order queries.
    function automatic range_req_t random_request();
        range_req_t req;
        int         a;
        int         b;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            req = make_write($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                             random_value());
            // Fields that a write ignores still carry noise.
            req.row_last = IDX_W'($urandom);
            req.col_last = IDX_W'($urandom);
        end
        else if (roll < 93)
        begin
            a = $urandom_range(0, ROWS - 1);
            b = $urandom_range(0, ROWS - 1);
            req = make_query((a < b) ? a : b, 0, (a < b) ? b : a, 0);
            a = $urandom_range(0, COLS - 1);
            b = $urandom_range(0, COLS - 1);
            req.col_first = IDX_W'((a < b) ? a : b);
            req.col_last  = IDX_W'((a < b) ? b : a);
            req.value     = VALUE_W'($urandom);
        end
        else
        begin
            req = make_query($urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom_range(0, 63));
            // Force at least one pair of corners out of order.
            a = $urandom_range(1, 63);
            b = $urandom_range(0, a - 1);
            if ($urandom_range(0, 1) == 0)
            begin
                req.row_first = IDX_W'(a);
                req.row_last  = IDX_W'(b);
            end
            else
            begin
                req.col_first = IDX_W'(a);
                req.col_last  = IDX_W'(b);
            end
        end
        return req;
    endfunction

    // Corner elements, field extremes, single cells, strips and out-of-order corners.
    task automatic test_directed();
        range_req_t req;
        send_request(make_write(0, 0, 16'sh8000));
        send_request(make_write(0, 63, 16'sh7fff));
        send_request(make_write(63, 0, 16'sh7fff));
        send_request(make_write(63, 63, 16'sh8000));
        req = make_write(21, 42, 16'sh5555);
        req.row_last = '1;
        req.col_last = '1;
        send_request(req);
        send_request(make_write(42, 21, 16'shaaaa));
        send_request(make_query(0, 0, 63, 63));
        // Overwrite of an element already set.
        send_request(make_write(0, 0, 16'sh0064));
        send_request(make_query(0, 0, 63, 63));
        send_request(make_query(0, 0, 0, 0));
        send_request(make_query(63, 63, 63, 63));
        send_request(make_query(0, 0, 5, 63));
        send_request(make_query(1, 1, 62, 62));
        send_request(make_query(63, 0, 63, 63));
        req = make_query(42, 21, 42, 21);
        req.value = 16'sh7fff;
        send_request(req);
        send_request(make_query(10, 0, 9, 63));
        send_request(make_query(0, 40, 63, 39));
        send_request(make_query(63, 63, 0, 0));
        send_request(make_write(21, 42, 16'sh0000));
        send_request(make_query(0, 42, 63, 42));
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_request(random_request());
        end
    endtask

    // Requests and results back to back with no idling on either side.
    task automatic test_back_to_back(input int count);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_mix(count);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // The receiver stops for a long stretch while requests keep coming, filling the block.
    task automatic test_output_hold();
        sender_gaps = 1'b0;
        hold_cycles = HOLD_LEN;
        test_random_mix(12);
        sender_gaps = 1'b1;
    endtask

    // The sender stops until every result is back, then resumes.
    task automatic test_drain_pause();
        test_random_mix(10);
        wait_all_results();
        test_random_mix(10);
    endtask

    // Receiver: random stalls, plus a long hold when a test asks for one.
    initial
    begin
        @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (sink_stall_left > 0)
            begin
                sink_stall_left--;
                out_ready <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                sink_stall_left = hold_cycles - 1;
                hold_cycles = 0;
                out_ready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                sink_stall_left = pick_gap();
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each returned result with the oldest expected one.
    always @(posedge clk)
    begin
        range_rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (expected_sums.size() == 0)
            begin
                if (error_count < 10)
                begin
                    $display("%0t: result with nothing expected: region_sum %0d status %0d",
                             $realtime, region_sum, status);
                end
                error_count++;
            end
            else
            begin
                want = expected_sums.pop_front();
                if (region_sum !== want.region_sum || status !== want.status)
                begin
                    if (error_count < 10)
                    begin
                        $display("%0t: mismatch: region_sum exp %0d got %0d, status exp %0d got %0d",
                                 $realtime, want.region_sum, region_sum, want.status, status);
                    end
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles where no request and no result move.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            for (int j = 0; j < COLS; j++)
            begin
                matrix_elem[i][j] = '0;
                col_running[i][j] = 0;
            end
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(600);
        test_output_hold();
        test_back_to_back(150);
        test_drain_pause();
        test_random_mix(600);

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d writes and %0d queries (%0d with corners out of order).",
                 writes_sent, queries_sent, bad_queries);
        $display("%0d results compared, with random stalls, a long output hold and a full drain.",
                 results_checked);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
